@@ rtl/ltdb_pkg.sv @@
// ----------------------------------------------------------------------------
// Last-touch dead block predictor package
// Sizes, table layout, frame history record and the signature function.
// ----------------------------------------------------------------------------
`default_nettype none

package ltdb_pkg;

  localparam int SETS = 64;
  localparam int WAYS = 8;
  localparam int SIG_BITS = 16;
  localparam int SIG_SHIFT = 4;

  localparam int FRAMES = SETS * WAYS;
  localparam int FRAME_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

  // The dead-signature table is stored as rows of TBL_WORD bits.
  localparam int COL_W = (SIG_BITS > 5) ? 5 : SIG_BITS - 1;
  localparam int ROW_W = SIG_BITS - COL_W;
  localparam int TBL_ROWS = 1 << ROW_W;
  localparam int TBL_WORD = 1 << COL_W;

  localparam int CLEAR_LEN = (TBL_ROWS > FRAMES) ? TBL_ROWS : FRAMES;
  localparam int CLR_W = $clog2(CLEAR_LEN) + 1;

  localparam logic OP_ACCESS = 1'b0;
  localparam logic OP_EVICT = 1'b1;

  typedef logic [SIG_BITS-1:0] sig_t;

  typedef struct packed {
    logic [31:0] prior_addr;
    logic [31:0] cur_addr;
    sig_t        sig;
    logic        sig_valid;
    logic        marked;
  } frame_t;

  function automatic sig_t make_signature(input logic [31:0] prior_addr,
                                          input logic [31:0] cur_addr,
                                          input logic [31:0] pc);
    logic [31:0] mix;
    mix = (prior_addr ^ cur_addr ^ pc) >> SIG_SHIFT;
    return mix[SIG_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/last_touch_dead_block_predictor.sv @@
// ----------------------------------------------------------------------------
// Last-touch dead block predictor
// Per-frame fill history and a dead-signature bit table, both held in
// synchronous memories and updated by read-modify-write.
// ----------------------------------------------------------------------------
// Usage: a request on the input channel (in_valid / in_stall) names a cache
// frame by set_index and way_index and is either an access (predict) or an
// eviction with refill. Each request gives exactly one result on the output
// channel (out_valid / out_stall) carrying predicted_dead and both totals.
// The block works on one request at a time. Each memory has a single read
// port, so a request runs in steps: one frame read, then a table row read and
// write-back at the old signature, then, for an access only, a table row read
// at the new signature. A request naming a frame outside the cache skips the
// table steps. The result appears in the same cycle that the block is ready
// again. After reset the block clears both memories in one pass over
// CLEAR_LEN addresses (2048 with the default sizes); in_stall stays high
// during it. A stalled result holds its output; the block may still take the
// next request, but then waits in its final step with in_stall high until
// the stalled result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module last_touch_dead_block_predictor (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        opcode,
  input  wire logic [5:0]  set_index,
  input  wire logic [2:0]  way_index,
  input  wire logic [31:0] pc,
  input  wire logic [31:0] new_address,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             predicted_dead,
  output logic [31:0]      last_touch_total,
  output logic [31:0]      mispredict_total
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_FRAME = 3'd2;
  localparam logic [2:0] ST_OLD   = 3'd3;
  localparam logic [2:0] ST_NEWRD = 3'd4;
  localparam logic [2:0] ST_NEW   = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  ltdb_pkg::frame_t frame_mem [ltdb_pkg::FRAMES];
  logic [ltdb_pkg::TBL_WORD-1:0] table_mem [ltdb_pkg::TBL_ROWS];

  logic [2:0] state;
  logic [ltdb_pkg::CLR_W-1:0] clr_cnt;
  logic [31:0] lt_count;
  logic [31:0] mis_count;

  logic req_op;
  logic req_in_range;
  logic [ltdb_pkg::FRAME_W-1:0] req_fidx;
  logic [31:0] req_pc;
  logic [31:0] req_naddr;

  ltdb_pkg::frame_t frame_rd;
  ltdb_pkg::sig_t sig_new;
  logic [ltdb_pkg::TBL_WORD-1:0] tbl_rd;
  logic dead;

  logic accept;
  logic out_free;
  logic in_range;
  logic [ltdb_pkg::FRAME_W-1:0] in_fidx;
  logic [ltdb_pkg::ROW_W-1:0] old_row;
  logic [ltdb_pkg::COL_W-1:0] old_col;
  logic [ltdb_pkg::ROW_W-1:0] new_row;
  logic [ltdb_pkg::COL_W-1:0] new_col;
  logic [ltdb_pkg::ROW_W-1:0] tbl_raddr;
  logic tbl_we;
  logic [ltdb_pkg::ROW_W-1:0] tbl_waddr;
  logic [ltdb_pkg::TBL_WORD-1:0] tbl_wdata;
  logic frame_we;
  ltdb_pkg::frame_t frame_wdata;
  logic is_access;

  assign in_stall = (state != ST_IDLE);
  assign accept = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign last_touch_total = lt_count;
  assign mispredict_total = mis_count;

  assign in_range = (32'(set_index) < 32'(ltdb_pkg::SETS)) &&
                    (32'(way_index) < 32'(ltdb_pkg::WAYS));
  assign in_fidx = ltdb_pkg::FRAME_W'(32'(set_index) * 32'(ltdb_pkg::WAYS) +
                                      32'(way_index));

  assign old_row = frame_rd.sig[ltdb_pkg::SIG_BITS-1:ltdb_pkg::COL_W];
  assign old_col = frame_rd.sig[ltdb_pkg::COL_W-1:0];
  assign new_row = sig_new[ltdb_pkg::SIG_BITS-1:ltdb_pkg::COL_W];
  assign new_col = sig_new[ltdb_pkg::COL_W-1:0];
  assign tbl_raddr = (state == ST_NEWRD) ? new_row : old_row;
  assign is_access = (req_op == ltdb_pkg::OP_ACCESS);

  always_comb begin
    tbl_we = 1'b0;
    tbl_waddr = old_row;
    tbl_wdata = tbl_rd;
    if (state == ST_CLEAR) begin
      tbl_we = 1'b1;
      tbl_waddr = clr_cnt[ltdb_pkg::ROW_W-1:0];
      tbl_wdata = '0;
    end else if (state == ST_OLD && frame_rd.sig_valid) begin
      tbl_we = 1'b1;
      tbl_wdata[old_col] = (req_op == ltdb_pkg::OP_EVICT);
    end
  end

  always_comb begin
    frame_we = (state == ST_DONE) && out_free && req_in_range;
    if (is_access) begin
      frame_wdata.prior_addr = frame_rd.prior_addr;
      frame_wdata.cur_addr = frame_rd.cur_addr;
      frame_wdata.sig = sig_new;
      frame_wdata.sig_valid = 1'b1;
      frame_wdata.marked = dead;
    end else begin
      frame_wdata.prior_addr = frame_rd.cur_addr;
      frame_wdata.cur_addr = req_naddr;
      frame_wdata.sig = '0;
      frame_wdata.sig_valid = 1'b0;
      frame_wdata.marked = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    tbl_rd <= table_mem[tbl_raddr];
    if (tbl_we) begin
      table_mem[tbl_waddr] <= tbl_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      frame_rd <= frame_mem[in_fidx];
    end
    if (state == ST_CLEAR) begin
      if (clr_cnt < ltdb_pkg::CLR_W'(ltdb_pkg::FRAMES)) begin
        frame_mem[clr_cnt[ltdb_pkg::FRAME_W-1:0]] <= '0;
      end
    end else if (frame_we) begin
      frame_mem[req_fidx] <= frame_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_op <= opcode;
      req_in_range <= in_range;
      req_fidx <= in_fidx;
      req_pc <= pc;
      req_naddr <= new_address;
    end
    if (state == ST_FRAME) begin
      sig_new <= ltdb_pkg::make_signature(frame_rd.prior_addr, frame_rd.cur_addr, req_pc);
      dead <= 1'b0;
    end else if (state == ST_NEW) begin
      dead <= tbl_rd[new_col];
    end
    if (state == ST_DONE && out_free) begin
      predicted_dead <= dead;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_cnt <= '0;
      out_valid <= 1'b0;
      lt_count <= '0;
      mis_count <= '0;
    end else begin
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + ltdb_pkg::CLR_W'(1);
          if (clr_cnt == ltdb_pkg::CLR_W'(ltdb_pkg::CLEAR_LEN - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state <= ST_FRAME;
          end
        end
        ST_FRAME: begin
          state <= req_in_range ? ST_OLD : ST_DONE;
        end
        ST_OLD: begin
          state <= is_access ? ST_NEWRD : ST_DONE;
        end
        ST_NEWRD: begin
          state <= ST_NEW;
        end
        ST_NEW: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
            if (req_in_range && is_access) begin
              lt_count <= lt_count + 32'(dead);
              mis_count <= mis_count + 32'(frame_rd.marked);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/ltdb_checker.sv @@
// ----------------------------------------------------------------------------
// Last-touch dead block predictor checker
// Port-level properties of the predictor, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module ltdb_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        predicted_dead,
  input wire logic [31:0] last_touch_total,
  input wire logic [31:0] mispredict_total
);

  // After reset the memories are being cleared, so nothing is taken or shown.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> in_stall && !out_valid)
    else $error("request taken or result shown right after reset");

  // One request at a time: the cycle after a request is taken, input stalls.
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second request taken while one is in progress");

  // A result never appears in the cycle right after a request is taken.
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && !out_valid) |=> !out_valid)
    else $error("result appeared too early");

  // A stalled result keeps its totals and its prediction.
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(predicted_dead) &&
      $stable(last_touch_total) && $stable(mispredict_total))
    else $error("stalled result changed");

endmodule

bind last_touch_dead_block_predictor ltdb_checker u_ltdb_checker (.*);

`default_nettype wire
